/* hdl/esd_pkg.sv */
// Shared types, constants and character helpers for the escape sequence token decoder.
`timescale 1ns / 1ps
`default_nettype none
package esd_pkg;

    localparam int OCTAL_DIGITS = 3;
    localparam int HEX_DIGITS   = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_TOKEN = 5'b00010,
        MODE_ESC   = 5'b00100,
        MODE_OCT   = 5'b01000,
        MODE_HEX   = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       token_end;
        logic       last_of_run;
    } t_res;

    function automatic logic is_white(input logic [7:0] c);
        is_white = (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        hex_digit = 5'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            t = c - CH_ZERO;
            hex_digit = {1'b1, t[3:0]};
        end else if ((c >= CH_LC_A) && (c <= CH_LC_F)) begin
            t = c - CH_LC_A + 8'd10;
            hex_digit = {1'b1, t[3:0]};
        end else if ((c >= CH_UC_A) && (c <= CH_UC_F)) begin
            t = c - CH_UC_A + 8'd10;
            hex_digit = {1'b1, t[3:0]};
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/escape_sequence_token_decoder_core.sv */
// Top level of the escape sequence token decoder.
// Takes one raw byte per transaction and returns decoded token bytes and
// end-of-token markers, one result per transaction, with last_of_run set on the
// final result of each input byte. A byte is accepted every cycle unless
// o_in_stall is raised; it is held in the input register, decoded there, and
// its results go into the four-entry result queue, whose head drives the
// output and sets the throughput: the output side moves one result per cycle
// while i_out_stall is low, so a byte that ends a numeric escape early and
// yields two results takes two output transfers, and input stall rises once
// the queue has fewer than two free entries. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module escape_sequence_token_decoder_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_stream,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_token_end,
    output logic            o_last_of_run
);

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_eos;
    logic           room;
    logic           fire;
    logic [1:0]     res_cnt;
    logic [1:0]     push_cnt;
    esd_pkg::t_res  res0, res1, head;

    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign push_cnt   = fire ? res_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    esd_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_in_byte (r_in_byte),
        .i_eos     (r_in_eos),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_count   (res_cnt)
    );

    esd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_room     (room),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_head     (head)
    );

    assign o_out_byte    = head.out_byte;
    assign o_token_end   = head.token_end;
    assign o_last_of_run = head.last_of_run;

endmodule
`default_nettype wire

/* hdl/esd_step.sv */
// Per-byte decode step: parser state registers and the result logic for one input byte.
`timescale 1ns / 1ps
`default_nettype none
module esd_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_eos,
    output esd_pkg::t_res      o_res0,
    output esd_pkg::t_res      o_res1,
    output logic [1:0]         o_count
);

    esd_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_digit_count, n_digit_count;
    logic [8:0]     r_escape_value, n_escape_value;
    logic           r_octal_stopped, n_octal_stopped;

    // token byte handling
    logic           tb_emit;
    logic           tb_end;
    esd_pkg::t_mode tb_mode;

    // numeric escape flush (first) and token byte (second)
    logic           a_emit;
    logic [7:0]     a_byte;
    logic           b_emit;
    logic           b_end;
    logic [7:0]     b_byte;

    logic [4:0]     hx;
    logic [3:0]     dig;
    logic           dig_ok;
    logic [2:0]     cnt;
    logic [2:0]     lim;
    logic [8:0]     val;

    always_comb begin
        tb_emit = 1'b1;
        tb_end  = 1'b0;
        tb_mode = esd_pkg::MODE_TOKEN;
        if (i_eos || esd_pkg::is_white(i_in_byte)) begin
            tb_end  = 1'b1;
            tb_mode = esd_pkg::MODE_IDLE;
        end else if (i_in_byte == esd_pkg::CH_BSLASH) begin
            tb_emit = 1'b0;
            tb_mode = esd_pkg::MODE_ESC;
        end
    end

    always_comb begin
        hx     = esd_pkg::hex_digit(i_in_byte);
        dig    = hx[3:0];
        dig_ok = 1'b0;
        if (!i_eos) begin
            if (r_mode == esd_pkg::MODE_OCT) begin
                dig_ok = (i_in_byte >= esd_pkg::CH_ZERO) && (i_in_byte <= esd_pkg::CH_NINE);
            end else begin
                dig_ok = hx[4];
            end
        end
        lim = (r_mode == esd_pkg::MODE_OCT) ? 3'(esd_pkg::OCTAL_DIGITS)
                                             : 3'(esd_pkg::HEX_DIGITS);
        cnt = {1'b0, r_digit_count} + 3'd1;
        val = r_escape_value;
        if (r_mode == esd_pkg::MODE_OCT) begin
            if (!dig[3] && !r_octal_stopped) begin
                val = {r_escape_value[5:0], dig[2:0]};
            end
        end else begin
            val = {r_escape_value[4:0], dig};
        end
    end

    always_comb begin
        n_mode          = r_mode;
        n_digit_count   = r_digit_count;
        n_escape_value  = r_escape_value;
        n_octal_stopped = r_octal_stopped;
        a_emit = 1'b0;
        a_byte = r_escape_value[7:0];
        b_emit = 1'b0;
        b_end  = 1'b0;
        b_byte = i_in_byte;
        unique case (r_mode)
            esd_pkg::MODE_TOKEN: begin
                b_emit = tb_emit;
                b_end  = tb_end;
                n_mode = tb_mode;
            end
            esd_pkg::MODE_ESC: begin
                b_emit = 1'b1;
                n_mode = esd_pkg::MODE_TOKEN;
                if (i_eos) begin
                    b_end  = 1'b1;
                    n_mode = esd_pkg::MODE_IDLE;
                end else begin
                    case (i_in_byte)
                        esd_pkg::CH_LC_A: b_byte = esd_pkg::CODE_BEL;
                        esd_pkg::CH_LC_B: b_byte = esd_pkg::CODE_BS;
                        esd_pkg::CH_LC_F: b_byte = esd_pkg::CODE_FF;
                        esd_pkg::CH_LC_N: b_byte = esd_pkg::CODE_LF;
                        esd_pkg::CH_LC_R: b_byte = esd_pkg::CODE_CR;
                        esd_pkg::CH_LC_T: b_byte = esd_pkg::CODE_HT;
                        esd_pkg::CH_LC_V: b_byte = esd_pkg::CODE_VT;
                        esd_pkg::CH_ZERO, esd_pkg::CH_X: begin
                            b_emit          = 1'b0;
                            n_mode          = (i_in_byte == esd_pkg::CH_ZERO) ?
                                              esd_pkg::MODE_OCT : esd_pkg::MODE_HEX;
                            n_digit_count   = 2'd0;
                            n_escape_value  = 9'd0;
                            n_octal_stopped = 1'b0;
                        end
                        default: b_byte = i_in_byte;
                    endcase
                end
            end
            esd_pkg::MODE_OCT, esd_pkg::MODE_HEX: begin
                if (!dig_ok) begin
                    a_emit = 1'b1;
                    b_emit = tb_emit;
                    b_end  = tb_end;
                    n_mode = tb_mode;
                end else begin
                    n_escape_value = val;
                    if ((r_mode == esd_pkg::MODE_OCT) && dig[3]) begin
                        n_octal_stopped = 1'b1;
                    end
                    if (cnt >= lim) begin
                        n_digit_count = 2'd0;
                        a_emit        = 1'b1;
                        a_byte        = val[7:0];
                        n_mode        = esd_pkg::MODE_TOKEN;
                    end else begin
                        n_digit_count = cnt[1:0];
                    end
                end
            end
            default: begin
                n_mode = esd_pkg::MODE_IDLE;
                if (!i_eos && !esd_pkg::is_white(i_in_byte)) begin
                    b_emit = tb_emit;
                    n_mode = tb_mode;
                end
            end
        endcase
    end

    always_comb begin
        o_res0  = '0;
        o_res1  = '0;
        o_count = {1'b0, a_emit} + {1'b0, b_emit};
        if (a_emit) begin
            o_res0.out_byte    = a_byte;
            o_res0.last_of_run = !b_emit;
            o_res1.out_byte    = b_end ? 8'd0 : b_byte;
            o_res1.token_end   = b_end;
            o_res1.last_of_run = 1'b1;
        end else begin
            o_res0.out_byte    = b_end ? 8'd0 : b_byte;
            o_res0.token_end   = b_end;
            o_res0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= esd_pkg::MODE_IDLE;
            r_digit_count   <= 2'd0;
            r_escape_value  <= 9'd0;
            r_octal_stopped <= 1'b0;
        end else if (i_fire) begin
            r_mode          <= n_mode;
            r_digit_count   <= n_digit_count;
            r_escape_value  <= n_escape_value;
            r_octal_stopped <= n_octal_stopped;
        end
    end

endmodule
`default_nettype wire

/* hdl/esd_queue.sv */
// Result queue: takes up to two results per cycle, hands out one per transaction.
`timescale 1ns / 1ps
`default_nettype none
module esd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_push_cnt,
    input  wire esd_pkg::t_res i_res0,
    input  wire esd_pkg::t_res i_res1,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_stall,
    output esd_pkg::t_res      o_head
);

    esd_pkg::t_res                    r_mem [esd_pkg::QUEUE_DEPTH];
    logic [esd_pkg::QPTR_W-1:0]       r_wp, r_rp;
    logic [esd_pkg::QCNT_W-1:0]       r_cnt, n_cnt;
    logic                             pop;
    logic [esd_pkg::QPTR_W-1:0]       wp1;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_cnt <= esd_pkg::QCNT_W'(esd_pkg::QUEUE_DEPTH - 2));
    assign wp1     = r_wp + esd_pkg::QPTR_W'(1);
    assign n_cnt   = r_cnt + esd_pkg::QCNT_W'(i_push_cnt) - esd_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + esd_pkg::QPTR_W'(i_push_cnt);
            r_rp  <= r_rp + esd_pkg::QPTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

/* hdl/esd_checker.sv */
// Port-level checker for the escape sequence token decoder and its bind.
`timescale 1ns / 1ps
`default_nettype none
module esd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_token_end,
    input wire logic       o_last_of_run
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_end) |-> (o_out_byte == 8'd0))
        else $error("token end with nonzero byte");

    a_run_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=> o_out_valid)
        else $error("second result of a run not ready");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_token_end)
             && $stable(o_last_of_run)))
        else $error("stalled result changed");

endmodule

bind escape_sequence_token_decoder_core esd_checker u_esd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_token_end   (o_token_end),
    .o_last_of_run (o_last_of_run)
);
`default_nettype wire
